>>> design/pgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_pkg: shared types and constants for the pileup genotype caller
// Widths, status and register index codes, and the stage payload structs.
// ----------------------------------------------------------------------------
package pgc_pkg;

  localparam int COUNT_W   = 16;
  localparam int WEIGHT_W  = 24;
  localparam int MINCOV_W  = 16;
  localparam int NUM_BASES = 4;
  localparam int BASE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int COV_W     = COUNT_W + 2;
  localparam int MUL_W     = COV_W + 1;
  localparam int PROD_W    = MUL_W + WEIGHT_W;
  localparam int SCORE_W   = PROD_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 24;

  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [COV_W-1:0]           cov_t;
  typedef logic [BASE_W-1:0]          base_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [PROD_W-1:0]   prod_w_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  localparam status_t ST_CALLED    = 2'd0;
  localparam status_t ST_LOW_COV   = 2'd1;
  localparam status_t ST_TIE       = 2'd2;
  localparam status_t ST_AMBIGUOUS = 2'd3;

  localparam cfg_idx_t CFG_MIN_COV = 3'd0;
  localparam cfg_idx_t CFG_ERR     = 3'd1;
  localparam cfg_idx_t CFG_MATCH   = 3'd2;
  localparam cfg_idx_t CFG_HALF    = 3'd3;
  localparam cfg_idx_t CFG_PRIOR   = 3'd4;

  localparam logic [MINCOV_W-1:0] MIN_COV_RESET = 16'd9;
  localparam weight_t ERR_RESET   = -24'sd524705;
  localparam weight_t MATCH_RESET = -24'sd66;
  localparam weight_t HALF_RESET  = -24'sd45470;
  localparam weight_t PRIOR_RESET = -24'sd452707;

  typedef struct packed {
    logic [MINCOV_W-1:0] min_cov;
    weight_t             err;
    weight_t             mat;
    weight_t             half;
    weight_t             prior;
  } cfg_t;

  // counts in rank order, highest first
  typedef struct packed {
    count_t c0;
    count_t c1;
    count_t c2;
    count_t c3;
    base_t  idx0;
    base_t  idx1;
    cov_t   cov;
  } rank_t;

  typedef struct packed {
    prod_w_t homo_match;
    prod_w_t homo_err;
    prod_w_t het_half;
    prod_w_t het_err;
    weight_t prior;
    logic    low_cov;
    logic    tie01;
    logic    tie12;
    base_t   idx0;
    base_t   idx1;
  } prod_t;

endpackage

>>> design/pgc_rank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_rank: input register and count ranking stage
// Captures the four counts, orders them highest first (lower index wins a
// tie) and registers the ordered counts, the top two indices and coverage.
// ----------------------------------------------------------------------------
module pgc_rank (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  pgc_pkg::count_t count_a_i,
  input  pgc_pkg::count_t count_c_i,
  input  pgc_pkg::count_t count_g_i,
  input  pgc_pkg::count_t count_t_i,
  output logic           valid_o,
  input  logic           ready_i,
  output pgc_pkg::rank_t rank_o
);
  import pgc_pkg::*;

  logic   in_v_r, in_v_nxt;
  count_t cnt_r [NUM_BASES];
  logic   rank_v_r, rank_v_nxt;
  rank_t  rank_r, rank_nxt;
  logic   rank_rdy;
  base_t  pos  [NUM_BASES];
  base_t  ord  [NUM_BASES];

  assign rank_rdy = !rank_v_r || ready_i;
  assign ready_o  = !in_v_r || rank_rdy;
  assign in_v_nxt   = ready_o ? valid_i : 1'b1;
  assign rank_v_nxt = rank_rdy ? in_v_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      rank_v_r <= 1'b0;
    end else begin
      in_v_r   <= in_v_nxt;
      rank_v_r <= rank_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      cnt_r[0] <= count_a_i;
      cnt_r[1] <= count_c_i;
      cnt_r[2] <= count_g_i;
      cnt_r[3] <= count_t_i;
    end
    if (in_v_r && rank_rdy) begin
      rank_r <= rank_nxt;
    end
  end

  // position of each base: how many others beat it
  always_comb begin
    for (int i = 0; i < NUM_BASES; i++) begin
      pos[i] = '0;
      for (int j = 0; j < NUM_BASES; j++) begin
        if ((cnt_r[j] > cnt_r[i]) || ((cnt_r[j] == cnt_r[i]) && (j < i))) begin
          pos[i] = pos[i] + base_t'(1);
        end
      end
    end
    for (int r = 0; r < NUM_BASES; r++) begin
      ord[r] = '0;
      for (int i = 0; i < NUM_BASES; i++) begin
        if (pos[i] == base_t'(r)) begin
          ord[r] = base_t'(i);
        end
      end
    end
  end

  always_comb begin
    rank_nxt.c0   = cnt_r[ord[0]];
    rank_nxt.c1   = cnt_r[ord[1]];
    rank_nxt.c2   = cnt_r[ord[2]];
    rank_nxt.c3   = cnt_r[ord[3]];
    rank_nxt.idx0 = ord[0];
    rank_nxt.idx1 = ord[1];
    rank_nxt.cov  = cov_t'(cnt_r[0]) + cov_t'(cnt_r[1])
                  + cov_t'(cnt_r[2]) + cov_t'(cnt_r[3]);
  end

  assign valid_o = rank_v_r;
  assign rank_o  = rank_r;

endmodule

>>> design/pgc_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_score: weighted product stage
// Forms the four count-by-weight products of the homozygous and the
// heterozygous scores and the coverage and count-tie flags.
// ----------------------------------------------------------------------------
module pgc_score (
  input  logic           clk,
  input  logic           rst_n,
  input  pgc_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  pgc_pkg::rank_t rank_i,
  output logic           valid_o,
  input  logic           ready_i,
  output pgc_pkg::prod_t prod_o
);
  import pgc_pkg::*;

  logic  v_r, v_nxt;
  prod_t prod_r, prod_nxt;
  cov_t  rest, top2, low2;
  logic signed [MUL_W-1:0] c0_s, rest_s, top2_s, low2_s;

  assign ready_o = !v_r || ready_i;
  assign v_nxt   = ready_o ? valid_i : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      prod_r <= prod_nxt;
    end
  end

  assign rest = rank_i.cov - cov_t'(rank_i.c0);
  assign top2 = cov_t'(rank_i.c0) + cov_t'(rank_i.c1);
  assign low2 = cov_t'(rank_i.c2) + cov_t'(rank_i.c3);

  assign c0_s   = $signed({1'b0, cov_t'(rank_i.c0)});
  assign rest_s = $signed({1'b0, rest});
  assign top2_s = $signed({1'b0, top2});
  assign low2_s = $signed({1'b0, low2});

  always_comb begin
    prod_nxt.homo_match = c0_s * cfg_i.mat;
    prod_nxt.homo_err   = rest_s * cfg_i.err;
    prod_nxt.het_half   = top2_s * cfg_i.half;
    prod_nxt.het_err    = low2_s * cfg_i.err;
    prod_nxt.prior      = cfg_i.prior;
    prod_nxt.low_cov    = rank_i.cov < cov_t'(cfg_i.min_cov);
    prod_nxt.tie01      = rank_i.c1 == rank_i.c0;
    prod_nxt.tie12      = rank_i.c2 == rank_i.c1;
    prod_nxt.idx0       = rank_i.idx0;
    prod_nxt.idx1       = rank_i.idx1;
  end

  assign valid_o = v_r;
  assign prod_o  = prod_r;

endmodule

>>> design/pgc_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgc_decide: score compare and result register
// Sums the products into the two log-likelihoods, compares them and
// registers the call status and the allele pair.
// ----------------------------------------------------------------------------
module pgc_decide (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  output logic             ready_o,
  input  pgc_pkg::prod_t   prod_i,
  output logic             valid_o,
  input  logic             ready_i,
  output pgc_pkg::status_t status_o,
  output pgc_pkg::base_t   first_o,
  output pgc_pkg::base_t   second_o,
  output logic             homo_o
);
  import pgc_pkg::*;

  logic    v_r, v_nxt;
  status_t status_r, status_nxt;
  base_t   first_r, first_nxt;
  base_t   second_r, second_nxt;
  logic    homo_r, homo_nxt;
  logic signed [SCORE_W-1:0] homo_score, het_score;

  assign ready_o = !v_r || ready_i;
  assign v_nxt   = ready_o ? valid_i : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      status_r <= status_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      homo_r   <= homo_nxt;
    end
  end

  assign homo_score = SCORE_W'(prod_i.homo_match) + SCORE_W'(prod_i.homo_err);
  assign het_score  = SCORE_W'(prod_i.het_half) + SCORE_W'(prod_i.het_err)
                    + SCORE_W'(prod_i.prior);

  always_comb begin
    status_nxt = ST_CALLED;
    first_nxt  = '0;
    second_nxt = '0;
    homo_nxt   = 1'b0;
    if (prod_i.low_cov) begin
      status_nxt = ST_LOW_COV;
    end else if (homo_score == het_score) begin
      status_nxt = ST_TIE;
    end else if (homo_score > het_score) begin
      if (prod_i.tie01) begin
        status_nxt = ST_AMBIGUOUS;
      end else begin
        first_nxt  = prod_i.idx0;
        second_nxt = prod_i.idx0;
        homo_nxt   = 1'b1;
      end
    end else begin
      if (prod_i.tie12) begin
        status_nxt = ST_AMBIGUOUS;
      end else begin
        first_nxt  = prod_i.idx0;
        second_nxt = prod_i.idx1;
      end
    end
  end

  assign valid_o  = v_r;
  assign status_o = status_r;
  assign first_o  = first_r;
  assign second_o = second_r;
  assign homo_o   = homo_r;

  a_nocall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && status_r != ST_CALLED) |-> (first_r == '0 && second_r == '0 && !homo_r))
    else $error("no-call result carries allele fields");

  a_homo_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && status_r == ST_CALLED && homo_r) |-> (first_r == second_r))
    else $error("homozygous call with differing alleles");

  a_het_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && status_r == ST_CALLED && !homo_r) |-> (first_r != second_r))
    else $error("heterozygous call with equal alleles");

endmodule

>>> design/pileup_genotype_caller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_genotype_caller: diploid genotype call for one pileup position
// Ranks the four base counts, scores best homozygous against best
// heterozygous genotype in Q8.16 log space and reports status and alleles.
// ----------------------------------------------------------------------------
// Pipeline: an accepted transaction passes in order through the input register,
//   rank register, product register and result register.
// Throughput: one transaction per cycle while out_ready is held high; each stage advances independently.
// Reset: synchronous active-low rst_n empties all stages and loads the
//   default weights and minimum coverage into the configuration registers.
module pileup_genotype_caller (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  pgc_pkg::cfg_idx_t      cfg_index,
  input  logic [pgc_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pgc_pkg::count_t        in_count_a,
  input  pgc_pkg::count_t        in_count_c,
  input  pgc_pkg::count_t        in_count_g,
  input  pgc_pkg::count_t        in_count_t,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pgc_pkg::status_t       out_call_status,
  output pgc_pkg::base_t         out_first_allele,
  output pgc_pkg::base_t         out_second_allele,
  output logic                   out_homozygous
);
  import pgc_pkg::*;

  cfg_t  cfg_r;
  logic  rank_valid, rank_ready;
  rank_t rank;
  logic  prod_valid, prod_ready;
  prod_t prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_cov <= MIN_COV_RESET;
      cfg_r.err     <= ERR_RESET;
      cfg_r.mat     <= MATCH_RESET;
      cfg_r.half    <= HALF_RESET;
      cfg_r.prior   <= PRIOR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_COV: cfg_r.min_cov <= cfg_wdata[MINCOV_W-1:0];
        CFG_ERR:     cfg_r.err     <= weight_t'(cfg_wdata[WEIGHT_W-1:0]);
        CFG_MATCH:   cfg_r.mat     <= weight_t'(cfg_wdata[WEIGHT_W-1:0]);
        CFG_HALF:    cfg_r.half    <= weight_t'(cfg_wdata[WEIGHT_W-1:0]);
        CFG_PRIOR:   cfg_r.prior   <= weight_t'(cfg_wdata[WEIGHT_W-1:0]);
        default: begin
          // drop writes to unused indices
        end
      endcase
    end
  end

  pgc_rank u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (in_valid),
    .ready_o   (in_ready),
    .count_a_i (in_count_a),
    .count_c_i (in_count_c),
    .count_g_i (in_count_g),
    .count_t_i (in_count_t),
    .valid_o   (rank_valid),
    .ready_i   (rank_ready),
    .rank_o    (rank)
  );

  pgc_score u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg_r),
    .valid_i (rank_valid),
    .ready_o (rank_ready),
    .rank_i  (rank),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .prod_o  (prod)
  );

  pgc_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (prod_valid),
    .ready_o  (prod_ready),
    .prod_i   (prod),
    .valid_o  (out_valid),
    .ready_i  (out_ready),
    .status_o (out_call_status),
    .first_o  (out_first_allele),
    .second_o (out_second_allele),
    .homo_o   (out_homozygous)
  );

endmodule

>>> sim/tb_pileup_genotype_caller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pileup_genotype_caller: self-checking testbench for the genotype caller
// Drives pileup base counts through the valid/ready input channel and checks
// every call against an in-bench scoring model that tracks the register
// settings. Directed corner cases come first, then randomized configuration
// phases with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_pileup_genotype_caller;
  import pgc_pkg::*;

  localparam cfg_idx_t CFG_UNUSED_LO = 3'd5;
  localparam cfg_idx_t CFG_UNUSED_HI = 3'd7;
  localparam int LONG_STALL = 300;

  typedef struct packed {
    count_t a;
    count_t c;
    count_t g;
    count_t t;
  } pileup_t;

  typedef struct packed {
    status_t status;
    base_t   first;
    base_t   second;
    logic    homo;
  } call_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  cfg_idx_t cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  count_t in_count_a = '0;
  count_t in_count_c = '0;
  count_t in_count_g = '0;
  count_t in_count_t = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  status_t out_call_status;
  base_t out_first_allele;
  base_t out_second_allele;
  logic out_homozygous;

  // register copies for the scoring model
  logic [MINCOV_W-1:0] min_cov_m = MIN_COV_RESET;
  weight_t err_w = ERR_RESET;
  weight_t match_w = MATCH_RESET;
  weight_t half_w = HALF_RESET;
  weight_t prior_w = PRIOR_RESET;

  pileup_t pending_pileups[$];
  call_t expected_calls[$];
  pileup_t cur_pileup = '0;
  int send_gap = 0;
  int ready_hold = 0;
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;
  int mismatches = 0;

  pileup_genotype_caller DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_count_a        (in_count_a),
    .in_count_c        (in_count_c),
    .in_count_g        (in_count_g),
    .in_count_t        (in_count_t),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_call_status   (out_call_status),
    .out_first_allele  (out_first_allele),
    .out_second_allele (out_second_allele),
    .out_homozygous    (out_homozygous)
  );

  always #5 clk = ~clk;

  // Rank the counts (ties to the lower base), score homozygous vs heterozygous.
  function automatic call_t predict_call(input pileup_t p);
    longint n[NUM_BASES];
    int order[NUM_BASES];
    int rank;
    longint cov, c0, c1, c2, c3, homo, het;
    call_t r;
    n[0] = p.a;
    n[1] = p.c;
    n[2] = p.g;
    n[3] = p.t;
    cov = n[0] + n[1] + n[2] + n[3];
    for (int i = 0; i < NUM_BASES; i++) begin
      rank = 0;
      for (int j = 0; j < NUM_BASES; j++)
        if (n[j] > n[i] || (n[j] == n[i] && j < i)) rank++;
      order[rank] = i;
    end
    r = '0;
    if (cov < longint'(min_cov_m)) begin
      r.status = ST_LOW_COV;
    end else begin
      c0 = n[order[0]];
      c1 = n[order[1]];
      c2 = n[order[2]];
      c3 = n[order[3]];
      homo = c0 * longint'(match_w) + (cov - c0) * longint'(err_w);
      het = (c0 + c1) * longint'(half_w) + (c2 + c3) * longint'(err_w) + longint'(prior_w);
      if (homo == het) begin
        r.status = ST_TIE;
      end else if (homo > het) begin
        if (c1 == c0) begin
          r.status = ST_AMBIGUOUS;
        end else begin
          r.status = ST_CALLED;
          r.first = base_t'(order[0]);
          r.second = base_t'(order[0]);
          r.homo = 1'b1;
        end
      end else if (c2 == c1) begin
        r.status = ST_AMBIGUOUS;
      end else begin
        r.status = ST_CALLED;
        r.first = base_t'(order[0]);
        r.second = base_t'(order[1]);
        r.homo = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic pileup_t random_pileup();
    pileup_t p;
    count_t v[NUM_BASES];
    int shape;
    int lead;
    shape = $urandom_range(0, 9);
    lead = $urandom_range(0, 3);
    for (int i = 0; i < NUM_BASES; i++) begin
      if (shape < 4)
        v[i] = count_t'($urandom_range(0, 40));
      else if (shape < 6)
        v[i] = count_t'($urandom);
      else if (shape < 8)
        v[i] = count_t'((i == lead) ? $urandom_range(10, 3000) : $urandom_range(0, 6));
      else if (shape == 8)
        v[i] = count_t'((i == lead || i == (lead + 1) % NUM_BASES) ? $urandom_range(8, 60)
                                                                   : $urandom_range(0, 3));
      else
        v[i] = count_t'($urandom_range(0, 2) * 7);  // lots of equal counts
    end
    p.a = v[0];
    p.c = v[1];
    p.g = v[2];
    p.t = v[3];
    return p;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  // Driver: hold the transaction until accepted, then load the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready)
        expected_calls.insert(expected_calls.size(), predict_call(cur_pileup));
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && !calm && pending_pileups.size() != 0 &&
            $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 13);
        if (send_gap != 0 || pending_pileups.size() == 0) begin
          if (send_gap != 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          cur_pileup = pending_pileups.pop_front();
          in_valid <= 1'b1;
          in_count_a <= cur_pileup.a;
          in_count_c <= cur_pileup.c;
          in_count_g <= cur_pileup.g;
          in_count_t <= cur_pileup.t;
        end
      end
    end
  end

  // Monitor: check each accepted call, then pick the next ready level.
  always @(posedge clk) begin
    call_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_call_status, out_first_allele, out_second_allele, out_homozygous};
        if (expected_calls.size() == 0) begin
          note_mismatch($sformatf("unexpected call status=%0d alleles=%0d/%0d homo=%0b",
                                  got.status, got.first, got.second, got.homo));
        end else begin
          want = expected_calls.pop_front();
          if (got.status !== want.status || got.first !== want.first ||
              got.second !== want.second || got.homo !== want.homo)
            note_mismatch($sformatf(
              {"expected status=%0d alleles=%0d/%0d homo=%0b, ",
               "got status=%0d alleles=%0d/%0d homo=%0b"},
              want.status, want.first, want.second, want.homo,
              got.status, got.first, got.second, got.homo));
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        ready_hold = LONG_STALL;
      end else if (ready_hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
        ready_hold = $urandom_range(1, 13);
      end
      if (ready_hold != 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MIN_COV: min_cov_m = value[MINCOV_W-1:0];
      CFG_ERR:     err_w = value;
      CFG_MATCH:   match_w = value;
      CFG_HALF:    half_w = value;
      CFG_PRIOR:   prior_w = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_regs(input int mc, input int e, input int m, input int h,
                          input int p);
    write_reg(CFG_MIN_COV, CFG_DW'(mc));
    write_reg(CFG_ERR, CFG_DW'(e));
    write_reg(CFG_MATCH, CFG_DW'(m));
    write_reg(CFG_HALF, CFG_DW'(h));
    write_reg(CFG_PRIOR, CFG_DW'(p));
  endtask

  task automatic random_regs();
    if ($urandom_range(0, 1) == 0)
      set_regs($urandom_range(0, 40), -$urandom_range(200000, 900000),
               -$urandom_range(0, 2000), -$urandom_range(40000, 50000),
               -$urandom_range(0, 900000));
    else
      set_regs($urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic push_pileup(input int a, input int c, input int g, input int t);
    pending_pileups.insert(pending_pileups.size(),
                           pileup_t'{count_t'(a), count_t'(c), count_t'(g), count_t'(t)});
  endtask

  task automatic push_random(input int n);
    repeat (n) pending_pileups.insert(pending_pileups.size(), random_pileup());
  endtask

  // Wait until every call is back, then let the pipeline settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_pileups.size() != 0 || in_valid || expected_calls.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset weights: coverage edges, clear calls, count ties, saturated counts
    push_pileup(0, 0, 0, 0);
    push_pileup(2, 2, 2, 2);
    push_pileup(3, 2, 2, 2);
    push_pileup(20, 0, 0, 0);
    push_pileup(0, 0, 0, 30);
    push_pileup(0, 15, 15, 0);
    push_pileup(1, 14, 13, 0);
    push_pileup(20, 10, 10, 0);
    push_pileup(0, 0, 9, 9);
    push_pileup(65535, 65535, 65535, 65535);
    push_pileup(65535, 0, 0, 0);
    push_pileup(0, 0, 0, 65535);
    push_pileup(65535, 65535, 0, 0);
    push_pileup(100, 3, 2, 1);
    push_pileup(5, 40, 38, 4);
    push_pileup(0, 1, 0, 50);
    push_pileup(7, 7, 7, 7);
    push_pileup(32768, 1, 0, 0);
    drain();

    // zero weights and prior: every scored site is a tie
    set_regs(0, 0, 0, 0, 0);
    push_pileup(0, 0, 0, 0);
    push_random(6);
    drain();

    // equal weights without prior: scores always equal
    set_regs(3, -1000, -1000, -1000, 0);
    push_random(6);
    drain();

    // harsh heterozygous prior: homozygous wins even on tied top counts
    set_regs(1, ERR_RESET, MATCH_RESET, HALF_RESET, -8388608);
    push_pileup(10, 10, 0, 0);
    push_pileup(3, 3, 3, 0);
    push_random(20);
    drain();

    // hold the output off long enough for the input to back up
    random_regs();
    long_hold_req = 1'b1;
    push_random(80);
    drain();

    // weight extremes; upper coverage bits dropped; unused indexes ignored
    set_regs(24'hFFFFFF, -8388608, 8388607, -8388608, 8388607);
    write_reg(CFG_UNUSED_LO, CFG_DW'($urandom));
    write_reg(CFG_UNUSED_HI, CFG_DW'($urandom));
    push_random(40);
    drain();

    set_regs(0, 8388607, -8388608, 8388607, -8388608);
    push_random(40);
    drain();

    repeat (4) begin
      random_regs();
      push_random(50);
      drain();
    end

    // back to defaults at full rate
    calm = 1'b1;
    set_regs(MIN_COV_RESET, ERR_RESET, MATCH_RESET, HALF_RESET, PRIOR_RESET);
    push_random(60);
    drain();

    if (mismatches == 0 && expected_calls.size() == 0)
      $display("tb_pileup_genotype_caller OK");
    else
      $display("tb_pileup_genotype_caller NOT OK");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_pileup_genotype_caller NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
design/pgc_pkg.sv
design/pgc_rank.sv
design/pgc_score.sv
design/pgc_decide.sv
design/pileup_genotype_caller.sv
sim/tb_pileup_genotype_caller.sv
